// ===== rtl/lfp_pkg.sv =====
// Shared types and constants of the length-prefixed frame parser.
`timescale 1ns / 1ps
`default_nettype none

package lfp_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgMinLength = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxLength = 1'b1;

  localparam logic [31:0] MaxLengthReset = 32'd65536;

  // Length window, both bounds exclusive
  typedef struct packed {
    logic [31:0] min_length;
    logic [31:0] max_length;
  } lfp_cfg_t;

  // One result word
  typedef struct packed {
    logic [7:0]  cmd_type;
    logic [7:0]  cmd_number;
    logic [31:0] sequence_number;
    logic [7:0]  version;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        frame_last;
    logic        length_error;
  } lfp_result_t;

endpackage

`default_nettype wire

// ===== rtl/length_prefixed_frame_parser_top.sv =====
// Top level of the length-prefixed frame parser.
//
//   channel  dir   handshake                payload
//   in       in    in_valid_i / in_ready_o  in_byte_i
//   out      out   out_valid_o / out_ready_i cmd_type_o .. length_error_o
//   cfg      in    cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One byte per cycle sustained unless out_ready_i stalls the result register; a result
// word is offered once it has passed the input register, then the result register.
// Header bytes produce no word; payload bytes and length errors produce one.
// The length window is checked with two 32-bit compares ahead of the result register.
// Reset returns the parser to the command type byte and empties both registers.
// A stall on out_ready_i holds the result register and, once a byte waits in the
// input register, drops in_ready_o in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_parser_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [7:0]                 in_byte_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [7:0]                      cmd_type_o,
  output logic [7:0]                      cmd_number_o,
  output logic [31:0]                     sequence_number_o,
  output logic [7:0]                      version_o,
  output logic [31:0]                     payload_length_o,
  output logic [7:0]                      payload_byte_o,
  output logic                            frame_last_o,
  output logic                            length_error_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [lfp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]                cfg_wdata_i
);

  lfp_pkg::lfp_cfg_t    cfg_q;
  lfp_pkg::lfp_result_t res;
  lfp_pkg::lfp_result_t out_res;
  logic                 byte_valid;
  logic [7:0]           byte_q;
  logic                 out_free;
  logic                 step;
  logic                 res_valid;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_length <= '0;
      cfg_q.max_length <= lfp_pkg::MaxLengthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lfp_pkg::CfgMinLength: cfg_q.min_length <= cfg_wdata_i;
        lfp_pkg::CfgMaxLength: cfg_q.max_length <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Consume a held byte whenever the result register can take a word
  assign step = byte_valid && out_free;

  lfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .take_i     (step),
    .valid_o    (byte_valid),
    .byte_o     (byte_q)
  );

  lfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (step),
    .byte_i      (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign cmd_type_o        = out_res.cmd_type;
  assign cmd_number_o      = out_res.cmd_number;
  assign sequence_number_o = out_res.sequence_number;
  assign version_o         = out_res.version;
  assign payload_length_o  = out_res.payload_length;
  assign payload_byte_o    = out_res.payload_byte;
  assign frame_last_o      = out_res.frame_last;
  assign length_error_o    = out_res.length_error;

endmodule

`default_nettype wire

// ===== rtl/lfp_in_stage.sv =====
// Input register: holds one received byte until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none

module lfp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // Accept a new word when empty or when the held word leaves this cycle
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

  // A held byte that is not taken must stay put
  a_hold_untaken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !take_i |=> valid_q && $stable(byte_q))
    else $error("input byte lost or changed while waiting");

endmodule

`default_nettype wire

// ===== rtl/lfp_parser.sv =====
// Header parser: tracks the phase, one result per payload byte or length error.
`timescale 1ns / 1ps
`default_nettype none

module lfp_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lfp_pkg::lfp_cfg_t cfg_i,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  output logic                  res_valid_o,
  output lfp_pkg::lfp_result_t  res_o
);

  typedef enum logic [3:0] {
    PhType, PhNumber, PhSeq0, PhSeq1, PhSeq2, PhSeq3, PhVersion,
    PhLen0, PhLen1, PhLen2, PhLen3, PhPayload
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  number_q, number_d;
  logic [31:0] seq_q, seq_d;
  logic [7:0]  version_q, version_d;
  logic [31:0] len_q, len_d;
  logic [31:0] count_q, count_d;

  logic [31:0] len_full;
  logic [31:0] count_inc;
  logic        len_ok;
  logic        last;

  assign len_full  = {len_q[23:0], byte_i};
  assign len_ok    = (len_full > cfg_i.min_length) && (len_full < cfg_i.max_length);
  assign count_inc = count_q + 32'd1;
  assign last      = count_inc >= len_q;

  // Decode the current phase into next state and an optional result
  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    number_d    = number_q;
    seq_d       = seq_q;
    version_d   = version_q;
    len_d       = len_q;
    count_d     = count_q;
    res_valid_o = 1'b0;
    res_o.cmd_type        = type_q;
    res_o.cmd_number      = number_q;
    res_o.sequence_number = seq_q;
    res_o.version         = version_q;
    res_o.payload_length  = len_q;
    res_o.payload_byte    = byte_i;
    res_o.frame_last      = last;
    res_o.length_error    = 1'b0;
    unique case (phase_q)
      PhNumber: begin
        number_d = byte_i;
        phase_d  = PhSeq0;
      end
      PhSeq0: begin
        seq_d   = {seq_q[23:0], byte_i};
        phase_d = PhSeq1;
      end
      PhSeq1: begin
        seq_d   = {seq_q[23:0], byte_i};
        phase_d = PhSeq2;
      end
      PhSeq2: begin
        seq_d   = {seq_q[23:0], byte_i};
        phase_d = PhSeq3;
      end
      PhSeq3: begin
        seq_d   = {seq_q[23:0], byte_i};
        phase_d = PhVersion;
      end
      PhVersion: begin
        version_d = byte_i;
        phase_d   = PhLen0;
      end
      PhLen0: begin
        len_d   = len_full;
        phase_d = PhLen1;
      end
      PhLen1: begin
        len_d   = len_full;
        phase_d = PhLen2;
      end
      PhLen2: begin
        len_d   = len_full;
        phase_d = PhLen3;
      end
      PhLen3: begin
        if (len_ok) begin
          len_d   = len_full;
          count_d = '0;
          phase_d = PhPayload;
        end else begin
          // Drop the frame: one error word, then back to the header
          len_d                = '0;
          phase_d              = PhType;
          res_valid_o          = 1'b1;
          res_o.payload_length = '0;
          res_o.payload_byte   = '0;
          res_o.frame_last     = 1'b1;
          res_o.length_error   = 1'b1;
        end
      end
      PhPayload: begin
        res_valid_o = 1'b1;
        if (last) begin
          count_d = '0;
          phase_d = PhType;
        end else begin
          count_d = count_inc;
        end
      end
      default: begin
        type_d  = byte_i;
        seq_d   = '0;
        len_d   = '0;
        phase_d = PhNumber;
      end
    endcase
  end

  // Advance the parser state on each consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhType;
      type_q    <= '0;
      number_q  <= '0;
      seq_q     <= '0;
      version_q <= '0;
      len_q     <= '0;
      count_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      type_q    <= type_d;
      number_q  <= number_d;
      seq_q     <= seq_d;
      version_q <= version_d;
      len_q     <= len_d;
      count_q   <= count_d;
    end
  end

  // Inside a payload the count always trails the length
  a_count_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> count_q < len_q)
    else $error("payload count reached frame length without leaving payload");

  // An accepted length leads into the payload
  a_len_to_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PhLen3 && !res_valid_o |=> phase_q == PhPayload)
    else $error("accepted length did not enter payload");

  // A rejected length returns to the header start
  a_err_to_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.length_error |=> phase_q == PhType)
    else $error("length error did not restart the header");

endmodule

`default_nettype wire

// ===== rtl/lfp_out_stage.sv =====
// Output register: holds one result word until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module lfp_out_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire lfp_pkg::lfp_result_t res_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output lfp_pkg::lfp_result_t      res_o
);

  logic                 valid_q, valid_d;
  lfp_pkg::lfp_result_t res_q;

  // Free when empty or when the held word is taken this cycle
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== tb/tb_length_prefixed_frame_parser_top.sv =====
// Self-checking testbench for the length-prefixed frame parser: byte stream in, checked words out.
`timescale 1ns / 1ps

module tb_length_prefixed_frame_parser_top;

  localparam int unsigned IdleLimit  = 4000;  // cycles with no word moving on either side
  localparam int unsigned LongHold   = 400;   // receiver hold-off that backs up the input
  localparam int unsigned MaxPayload = 24;    // longest accepted frame the stimulus sends
  localparam int unsigned PhaseBytes = 190;   // random bytes per length window

  // Parser position inside a frame
  typedef enum logic [3:0] {
    PhCmdType, PhCmdNumber, PhSeq0, PhSeq1, PhSeq2, PhSeq3, PhVersion,
    PhLen0, PhLen1, PhLen2, PhLen3, PhPayload
  } parse_phase_e;

  // Tracks the parser state and the words it must emit, in order
  class frame_scoreboard;
    logic [31:0]          min_len;
    logic [31:0]          max_len;
    parse_phase_e         parse_phase;
    logic [7:0]           held_cmd_type;
    logic [7:0]           held_cmd_number;
    logic [31:0]          held_seq;
    logic [7:0]           held_version;
    logic [31:0]          held_len;
    logic [31:0]          payload_count;
    lfp_pkg::lfp_result_t expected_words[$];
    int unsigned          mismatches;

    function new();
      min_len         = '0;
      max_len         = lfp_pkg::MaxLengthReset;
      parse_phase     = PhCmdType;
      held_cmd_type   = '0;
      held_cmd_number = '0;
      held_seq        = '0;
      held_version    = '0;
      held_len        = '0;
      payload_count   = '0;
      mismatches      = 0;
    endfunction

    function void set_window(logic [31:0] lo, logic [31:0] hi);
      min_len = lo;
      max_len = hi;
    endfunction

    function lfp_pkg::lfp_result_t make_word(logic [31:0] len, logic [7:0] data, logic last,
                                             logic err);
      lfp_pkg::lfp_result_t w;
      w.cmd_type        = held_cmd_type;
      w.cmd_number      = held_cmd_number;
      w.sequence_number = held_seq;
      w.version         = held_version;
      w.payload_length  = len;
      w.payload_byte    = data;
      w.frame_last      = last;
      w.length_error    = err;
      return w;
    endfunction

    // Queue one word at the tail of the expected list
    function void expect_word(lfp_pkg::lfp_result_t w);
      expected_words = {expected_words, w};
    endfunction

    // Advance the parse by one accepted byte and queue the word it causes
    function void note_byte(logic [7:0] b);
      logic last;
      case (parse_phase)
        PhCmdNumber: begin
          held_cmd_number = b;
          parse_phase = parse_phase.next();
        end
        PhSeq0, PhSeq1, PhSeq2, PhSeq3: begin
          held_seq = {held_seq[23:0], b};
          parse_phase = parse_phase.next();
        end
        PhVersion: begin
          held_version = b;
          parse_phase = parse_phase.next();
        end
        PhLen0, PhLen1, PhLen2: begin
          held_len = {held_len[23:0], b};
          parse_phase = parse_phase.next();
        end
        PhLen3: begin
          held_len = {held_len[23:0], b};
          if (held_len > min_len && held_len < max_len) begin
            payload_count = '0;
            parse_phase = PhPayload;
          end else begin
            // out-of-window length: one error word, back to the header
            held_len = '0;
            parse_phase = PhCmdType;
            expect_word(make_word('0, '0, 1'b1, 1'b1));
          end
        end
        PhPayload: begin
          payload_count = payload_count + 32'd1;
          last = (payload_count >= held_len);
          expect_word(make_word(held_len, b, last, 1'b0));
          if (last) begin
            payload_count = '0;
            parse_phase = PhCmdType;
          end
        end
        default: begin
          held_cmd_type = b;
          held_seq = '0;
          held_len = '0;
          parse_phase = PhCmdNumber;
        end
      endcase
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 1'b1;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1'b0;
    endfunction

    // Compare one delivered word with the oldest expected one
    function void check_word(lfp_pkg::lfp_result_t got);
      lfp_pkg::lfp_result_t want;
      bit ok;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      ok = field_ok("cmd_type", want.cmd_type, got.cmd_type)
         & field_ok("cmd_number", want.cmd_number, got.cmd_number)
         & field_ok("sequence_number", want.sequence_number, got.sequence_number)
         & field_ok("version", want.version, got.version)
         & field_ok("payload_length", want.payload_length, got.payload_length)
         & field_ok("payload_byte", want.payload_byte, got.payload_byte)
         & field_ok("frame_last", want.frame_last, got.frame_last)
         & field_ok("length_error", want.length_error, got.length_error);
      if (!ok) mismatches++;
    endfunction
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [7:0]                  in_byte_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [7:0]                  cmd_type_o;
  logic [7:0]                  cmd_number_o;
  logic [31:0]                 sequence_number_o;
  logic [7:0]                  version_o;
  logic [31:0]                 payload_length_o;
  logic [7:0]                  payload_byte_o;
  logic                        frame_last_o;
  logic                        length_error_o;
  logic                        cfg_we_i    = 1'b0;
  logic [lfp_pkg::CfgIdxW-1:0] cfg_idx_i   = lfp_pkg::CfgMinLength;
  logic [31:0]                 cfg_wdata_i = '0;

  frame_scoreboard sb;
  logic [7:0]      byte_stream[$];
  int unsigned     burst_left;
  int unsigned     quiet_cycles;
  bit              long_hold_req;

  length_prefixed_frame_parser_top i_dut (.*);

  always #2 clk_i = ~clk_i;

  // Check every word that leaves the block
  always @(posedge clk_i) begin
    lfp_pkg::lfp_result_t got_word;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_word = {cmd_type_o, cmd_number_o, sequence_number_o, version_o,
                  payload_length_o, payload_byte_o, frame_last_o, length_error_o};
      sb.check_word(got_word);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: stall on changing patterns, plus long hold-offs on request
  initial begin : ready_pattern
    int unsigned mode;
    int unsigned span;
    int unsigned hold_left;
    int unsigned tick;
    mode = 0;
    span = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 160);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LongHold;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // Append one byte to the stream waiting to be sent
  function automatic void put_byte(logic [7:0] b);
    byte_stream = {byte_stream, b};
  endfunction

  function automatic void queue_header(logic [7:0] cmd, logic [7:0] num, logic [31:0] seq,
                                       logic [7:0] ver, logic [31:0] len);
    put_byte(cmd);
    put_byte(num);
    for (int i = 3; i >= 0; i--) put_byte(seq[8*i +: 8]);
    put_byte(ver);
    for (int i = 3; i >= 0; i--) put_byte(len[8*i +: 8]);
  endfunction

  // Favor short accepted lengths; otherwise hit the window edges and wide values
  function automatic logic [31:0] pick_length();
    longint first_ok;
    longint last_ok;
    logic [31:0] cand;
    first_ok = longint'({32'd0, sb.min_len}) + 1;
    last_ok  = longint'({32'd0, sb.max_len}) - 1;
    if (last_ok > MaxPayload) last_ok = MaxPayload;
    if (first_ok <= last_ok && $urandom_range(0, 9) < 6)
      return $urandom_range(32'(first_ok), 32'(last_ok));
    case ($urandom_range(0, 5))
      0: cand = '0;
      1: cand = sb.min_len;
      2: cand = sb.max_len;
      3: cand = sb.max_len + 32'd1;
      4: cand = $urandom;
      default: cand = '1;
    endcase
    // never open a frame too long to send
    if (cand > sb.min_len && cand < sb.max_len && cand > MaxPayload) cand = '0;
    return cand;
  endfunction

  // Fill the stream with frames; add noise only where no long frame can open
  function automatic void build_random_stream(int unsigned budget);
    bit noisy;
    int unsigned pick;
    int unsigned keep;
    logic [31:0] len;
    noisy = (sb.max_len <= 65) || ({32'd0, sb.min_len} + 64'd1 >= {32'd0, sb.max_len});
    while (byte_stream.size() < budget) begin
      pick = $urandom_range(0, 9);
      if (noisy && pick == 0) begin
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
      end else if (noisy && pick == 1) begin
        // broken frame: header cut short
        keep = $urandom_range(1, 10);
        queue_header(8'($urandom), 8'($urandom), $urandom, 8'($urandom), $urandom);
        repeat (11 - keep) void'(byte_stream.pop_back());
      end else begin
        len = pick_length();
        queue_header(8'($urandom), 8'($urandom), $urandom, 8'($urandom), len);
        if (len > sb.min_len && len < sb.max_len)
          repeat (len) put_byte(8'($urandom));
      end
    end
  endfunction

  // Offer queued bytes in bursts with random gaps
  task automatic send_bytes();
    logic [7:0] b;
    int unsigned gap;
    while (byte_stream.size() > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      b = byte_stream.pop_front();
      in_valid_i <= 1'b1;
      in_byte_i  <= b;
      do @(posedge clk_i); while (!in_ready_o);
      sb.note_byte(b);
      burst_left--;
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Finish any open frame, drain all words, let the pipeline empty
  task automatic settle();
    while (sb.parse_phase != PhCmdType) begin
      put_byte(8'($urandom));
      send_bytes();
    end
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_window(logic [31:0] lo, logic [31:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= lfp_pkg::CfgMinLength;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_idx_i   <= lfp_pkg::CfgMaxLength;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_window(lo, hi);
  endtask

  initial begin : stimulus
    logic [31:0] win_min[7];
    logic [31:0] win_max[7];
    win_min = '{32'd0, 32'd3, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd7, 32'd0};
    win_max = '{lfp_pkg::MaxLengthReset, 32'd12, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
                32'd8, 32'd20};
    sb = new();
    burst_left = 0;
    long_hold_req = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all-ones header with payload extremes, then a zero length
    queue_header(8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'd2);
    put_byte(8'hFF);
    put_byte(8'h00);
    queue_header(8'h00, 8'h00, 32'h0, 8'h00, 32'd0);
    send_bytes();

    // Random frames under each length window, starting from the reset one
    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        settle();
        set_window(win_min[p], win_max[p]);
      end
      if (p == 1 || p == 6) long_hold_req = 1'b1;
      build_random_stream(PhaseBytes);
      send_bytes();
    end
    settle();

    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
